/* hdl/assert_macros.svh */
// Assertion macros shared by the tick generator RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/atg_pkg.sv */
// Shared types and constants for the axis tick generator.
// No dependencies.
`default_nettype none

package atg_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = 8;
  localparam int PROD_W      = VALUE_WIDTH + POS_W;
  localparam int IN_W        = 31;
  localparam int STEP_W      = 29;
  localparam int CFG_IDX_W   = 8;

  localparam logic [2:0] MAX_TICKS = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM = 8'd3;

  localparam logic [POS_W-1:0] BOX_LEFT_RST   = 8'd24;
  localparam logic [POS_W-1:0] BOX_RIGHT_RST  = 8'd148;
  localparam logic [POS_W-1:0] BOX_TOP_RST    = 8'd12;
  localparam logic [POS_W-1:0] BOX_BOTTOM_RST = 8'd92;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_STEP,
    ST_MOD_GO,
    ST_MOD,
    ST_CHECK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hdl/atg_ladder.sv */
// 1-2-5 decade step search: one candidate multiple per cycle.
// Depends on atg_pkg.
`default_nettype none
`include "assert_macros.svh"

module atg_ladder import atg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] range_in,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] step
);

  localparam int CW = VALUE_WIDTH + 5;
  localparam logic [1:0] PH_SIX    = 2'd0;
  localparam logic [1:0] PH_TWELVE = 2'd1;
  localparam logic [1:0] PH_THIRTY = 2'd2;

  logic                   busy;
  logic [1:0]             phase;
  logic [VALUE_WIDTH-1:0] s;
  logic [CW-1:0]          s_w;
  logic [CW-1:0]          cand;
  logic [VALUE_WIDTH-1:0] step_pick;
  logic                   hit;

  always_comb begin
    s_w = CW'(s);
    case (phase)
      PH_SIX: begin
        cand      = (s_w << 2) + (s_w << 1);
        step_pick = s;
      end
      PH_TWELVE: begin
        cand      = (s_w << 3) + (s_w << 2);
        step_pick = VALUE_WIDTH'(s_w << 1);
      end
      default: begin
        cand      = (s_w << 5) - (s_w << 1);
        step_pick = VALUE_WIDTH'((s_w << 2) + s_w);
      end
    endcase
    hit = cand >= CW'(range_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_SIX;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= PH_SIX;
      end else if (busy) begin
        if (hit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (phase == PH_THIRTY) begin
          phase <= PH_SIX;
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s <= VALUE_WIDTH'(1);
    end else if (busy) begin
      if (hit) begin
        step <= step_pick;
      end else if (phase == PH_THIRTY) begin
        s <= VALUE_WIDTH'((s_w << 3) + (s_w << 1));
      end
    end
  end

  `ASSERT_IMPL(a_lad_step_nz, done, step != '0, "ladder produced a zero step")

endmodule

`default_nettype wire

/* hdl/atg_mul.sv */
// Bit-serial shift-add multiplier: value times 8-bit span, one span bit a cycle.
// Depends on atg_pkg.
`default_nettype none
`include "assert_macros.svh"

module atg_mul import atg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] multiplicand,
  input  logic [POS_W-1:0]       multiplier,
  output logic                   done,
  output logic [PROD_W-1:0]      product
);

  localparam int CNT_W = $clog2(POS_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PROD_W-1:0] a_sh;
  logic [POS_W-1:0]  b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(POS_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh    <= PROD_W'(multiplicand);
      b_sh    <= multiplier;
      product <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        product <= product + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  `ASSERT_NEXT(a_mul_run, start, busy && !done, "multiplier did not start")

endmodule

`default_nettype wire

/* hdl/atg_div.sv */
// Bit-serial restoring divider, one quotient bit a cycle; shared by the
// first-tick remainder and the grid position division. Depends on atg_pkg.
`default_nettype none
`include "assert_macros.svh"

module atg_div import atg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PROD_W-1:0]      dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [POS_W-1:0]       quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(PROD_W);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [PROD_W-1:0]      num;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   fits;

  assign rem_sh = {remainder, num[PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign fits   = !diff[VALUE_WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      num       <= num << 1;
      remainder <= fits ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
      quotient  <= {quotient[POS_W-2:0], fits};
    end
  end

  `ASSERT_IMPL(a_div_rem_lt, busy, remainder < dvs, "partial remainder not below divisor")

endmodule

`default_nettype wire

/* hdl/axis_tick_generator_core.sv */
// Axis tick generator top: control FSM, box registers, output register.
// Flow: a 1-2-5 step search, a remainder division to place the first tick, then
// per tick a multiply and a divide to map it into the box; a zero range takes the
// box middle instead. An inverted range gives a single error item.
// One request at a time; the next is taken once its last item is registered.
// Reset clears control and sets the box to 24/148/12/92. Uses atg_pkg.
`default_nettype none
`include "assert_macros.svh"

module axis_tick_generator_core import atg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [IN_W-1:0]      range_low,
  input  logic [IN_W-1:0]      range_high,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IN_W-1:0]      tick_value,
  output logic [STEP_W-1:0]    tick_step,
  output logic [POS_W-1:0]     grid_pos,
  output logic                 range_error,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic [POS_W-1:0] box_left, box_right, box_top, box_bottom;

  logic                          vert;
  logic signed [VALUE_WIDTH-1:0] lo, hi, v;
  logic [VALUE_WIDTH-1:0]        rng, st;
  logic [2:0]                    tick_cnt;
  logic [PROD_W-1:0]             numer, numer_next;
  logic                          numer_neg, numer_neg_next;
  logic [POS_W-1:0]              pos;

  logic signed [VALUE_WIDTH-1:0] lo_in, hi_in, v_first, v_next;
  logic [VALUE_WIDTH-1:0]        rng_in, lo_mag, adj, d, half;
  logic                          inverted, in_fire, out_free, check_ok, is_last;
  logic [POS_W-1:0]              edge_a, edge_b, span_mag, mid, pos_calc;
  logic [POS_W:0]                mid_sum;
  logic                          span_neg;
  logic                          err_fields_zero;

  logic                   lad_start, lad_done;
  logic [VALUE_WIDTH-1:0] lad_step;
  logic                   mul_start, mul_done;
  logic [PROD_W-1:0]      mul_prod;
  logic                   div_start, div_done;
  logic [PROD_W-1:0]      div_dividend;
  logic [VALUE_WIDTH-1:0] div_divisor, div_rem;
  logic [POS_W-1:0]       div_quo;
  logic                   load_tick, load_err;

  // input decode
  assign lo_in    = VALUE_WIDTH'($signed(range_low));
  assign hi_in    = VALUE_WIDTH'($signed(range_high));
  assign inverted = hi_in < lo_in;
  assign rng_in   = VALUE_WIDTH'(hi_in - lo_in);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // first tick: smallest multiple of the step at or above lo
  assign lo_mag  = lo[VALUE_WIDTH-1] ? VALUE_WIDTH'(-lo) : VALUE_WIDTH'(lo);
  assign adj     = lo[VALUE_WIDTH-1] ? div_rem :
                   ((div_rem == '0) ? '0 : st - div_rem);
  assign v_first = lo + $signed(adj);

  // mapping into the box
  assign edge_a   = vert ? box_top : box_left;
  assign edge_b   = vert ? box_bottom : box_right;
  assign span_neg = edge_b < edge_a;
  assign span_mag = span_neg ? edge_a - edge_b : edge_b - edge_a;
  assign mid_sum  = {1'b0, edge_a} + {1'b0, edge_b};
  assign mid      = mid_sum[POS_W:1];
  assign d        = VALUE_WIDTH'(v - lo);
  assign half     = rng >> 1;

  always_comb begin
    if (!span_neg) begin
      numer_next     = mul_prod + PROD_W'(half);
      numer_neg_next = 1'b0;
    end else if (mul_prod > PROD_W'(half)) begin
      numer_next     = mul_prod - PROD_W'(half);
      numer_neg_next = 1'b1;
    end else begin
      numer_next     = PROD_W'(half) - mul_prod;
      numer_neg_next = 1'b0;
    end
  end

  assign pos_calc = vert ? (numer_neg ? edge_b + div_quo : edge_b - div_quo)
                         : (numer_neg ? edge_a - div_quo : edge_a + div_quo);

  assign v_next   = v + $signed(st);
  assign check_ok = (v <= hi) && (tick_cnt != MAX_TICKS);
  assign is_last  = (v_next > hi) || (tick_cnt == MAX_TICKS - 3'd1);

  assign div_dividend = (state == ST_MOD_GO) ? PROD_W'(lo_mag) : numer;
  assign div_divisor  = (state == ST_MOD_GO) ? st : rng;

  atg_ladder u_ladder (
    .clk      (clk),
    .rst      (rst),
    .start    (lad_start),
    .range_in (rng),
    .done     (lad_done),
    .step     (lad_step)
  );

  atg_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (d),
    .multiplier   (span_mag),
    .done         (mul_done),
    .product      (mul_prod)
  );

  atg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    lad_start  = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_tick  = 1'b0;
    load_err   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (inverted) begin
            state_next = ST_ERR;
          end else begin
            lad_start  = 1'b1;
            state_next = ST_STEP;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_err   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (lad_done) state_next = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        div_start  = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (div_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!check_ok) begin
          state_next = ST_IDLE;
        end else if (rng == '0) begin
          state_next = ST_EMIT;
        end else begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_tick  = 1'b1;
          state_next = is_last ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= BOX_LEFT_RST;
      box_right  <= BOX_RIGHT_RST;
      box_top    <= BOX_TOP_RST;
      box_bottom <= BOX_BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_LEFT:   box_left   <= cfg_data;
        CFG_BOX_RIGHT:  box_right  <= cfg_data;
        CFG_BOX_TOP:    box_top    <= cfg_data;
        CFG_BOX_BOTTOM: box_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_MOD && div_done) begin
        tick_cnt <= '0;
      end else if (load_tick) begin
        tick_cnt <= tick_cnt + 3'd1;
      end
      if (load_tick || load_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vert <= op;
      lo   <= lo_in;
      hi   <= hi_in;
      rng  <= rng_in;
    end
    if (lad_done) begin
      st <= lad_step;
    end
    if (state == ST_MOD && div_done) begin
      v <= v_first;
    end else if (load_tick) begin
      v <= v_next;
    end
    if (state == ST_CHECK && check_ok && rng == '0) begin
      pos <= mid;
    end else if (state == ST_DIV && div_done) begin
      pos <= pos_calc;
    end
    if (state == ST_MUL && mul_done) begin
      numer     <= numer_next;
      numer_neg <= numer_neg_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_err) begin
      tick_value  <= '0;
      tick_step   <= '0;
      grid_pos    <= '0;
      range_error <= 1'b1;
      last        <= 1'b0;
    end else if (load_tick) begin
      tick_value  <= v[IN_W-1:0];
      tick_step   <= st[STEP_W-1:0];
      grid_pos    <= pos;
      range_error <= 1'b0;
      last        <= is_last;
    end
  end

  assign err_fields_zero = tick_value == '0 && tick_step == '0 && grid_pos == '0 && !last;

  `ASSERT_IMPL(a_err_clean, out_valid && range_error, err_fields_zero, "error item carries data")
  `ASSERT_IMPL(a_step_nz, out_valid && !range_error, tick_step != '0, "tick item with zero step")
  `ASSERT_IMPL(a_tick_cap, state == ST_EMIT, tick_cnt != MAX_TICKS, "tick count overrun")

endmodule

`default_nettype wire
